// ----- hw/rtl/buddy_block_allocator_macros.svh -----
// Assertion macros used by the buddy allocator top level.
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BBA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hw/rtl/bba_pkg.sv -----
// Types and constants of the buddy block allocator.
package bba_pkg;

    // Width of a stored block order and of a tag (order plus used flag).
    localparam int ORD_W = 5;
    localparam int TAG_W = ORD_W + 1;

    // Operation codes of an input word.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_GRANTED   = 3'd0;
    localparam logic [2:0] ST_ZERO      = 3'd1;
    localparam logic [2:0] ST_TOO_LARGE = 3'd2;
    localparam logic [2:0] ST_NO_MEMORY = 3'd3;
    localparam logic [2:0] ST_FREED     = 3'd4;
    localparam logic [2:0] ST_IGNORED   = 3'd5;

    typedef struct packed {
        logic [2:0]  status;
        logic [13:0] data_address;
        logic [3:0]  block_order;
    } t_result;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_SIZE,
        S_A_UNLINK,
        S_A_SPLIT,
        S_A_SPLIT2,
        S_A_MARK,
        S_F_CHECK,
        S_F_TAG,
        S_F_BUDDY,
        S_F_BCHK,
        S_F_UNLINK,
        S_F_PUSH,
        S_F_PUSH2,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/buddy_block_allocator.sv -----
// Top level of the buddy block allocator: handshakes and result register.
//
//   channel   direction  handshake          word fields
//   input     in         i_valid, o_stall   i_op, i_size_bytes, i_address
//   result    out        o_valid, i_stall   o_status, o_data_address, o_block_order
//
// One word is worked at a time. An allocate splits its block once per order
// between the found and the needed order; a free merges with its buddy while the
// buddy is free and of the same order, up to the top order. The next word can be
// taken in the same cycle the result appears. LEAF_BYTES must be a power of two; the block does not check it.
// After reset a clearing pass fills all 2**TOP_ORDER entries of the memories;
// o_stall is high during it. A held result stalls the sequencer only when the
// next result is ready.
module buddy_block_allocator #(
    parameter int LEAF_BYTES   = 16,
    parameter int TOP_ORDER    = 10,
    parameter int HEADER_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_size_bytes,
    input  logic [13:0] i_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [13:0] o_data_address,
    output logic [3:0]  o_block_order
);
    import bba_pkg::*;
`include "buddy_block_allocator_macros.svh"

    logic    idle, done, start, hold;
    t_result res;
    logic    r_valid, n_valid;
    t_result r_res;

    assign start   = i_valid && !o_stall;
    assign o_stall = !idle;
    assign hold    = r_valid && i_stall;

    bba_ctrl #(
        .LEAF_BYTES(LEAF_BYTES), .TOP_ORDER(TOP_ORDER), .HEADER_BYTES(HEADER_BYTES)
    ) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_hold(hold), .i_op(i_op),
        .i_size_bytes(i_size_bytes), .i_address(i_address),
        .o_idle(idle), .o_done(done), .o_result(res)
    );

    // Result word is held until the receiver takes it.
    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) n_valid = 1'b0;
        if (done) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_res <= res;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_res.status;
    assign o_data_address = r_res.data_address;
    assign o_block_order  = r_res.block_order;

    `BBA_ASSERT_IMP(a_addr_only_grant, i_clk, i_rst_n, o_valid && o_status != ST_GRANTED, o_data_address == 14'd0)
    `BBA_ASSERT_IMP(a_order_range, i_clk, i_rst_n, o_valid, 32'(o_block_order) <= TOP_ORDER)
    `BBA_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start, o_stall)

endmodule

// ----- hw/rtl/bba_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, and a read port whose data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bba_ctrl.sv -----
// Sequencer of the buddy allocator: tag and link memories, free list heads.
module bba_ctrl #(
    parameter int LEAF_BYTES   = 16,
    parameter int TOP_ORDER    = 10,
    parameter int HEADER_BYTES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_hold,
    input  logic            i_op,
    input  logic [15:0]     i_size_bytes,
    input  logic [13:0]     i_address,
    output logic            o_idle,
    output logic            o_done,
    output bba_pkg::t_result o_result
);
    import bba_pkg::*;

    // LEAF_BYTES must be a power of two (the block does not check it), so the leaf index is a shift and a mask.
    localparam int LW    = TOP_ORDER;
    localparam int KW    = TOP_ORDER + 1;
    localparam int HIW   = $clog2(TOP_ORDER + 1);
    localparam int NLEAF = 1 << TOP_ORDER;
    localparam int LB_SH = $clog2(LEAF_BYTES);
    localparam logic [KW-1:0]    NIL     = KW'(NLEAF);
    localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(TOP_ORDER);
    localparam logic [13:0]      LB_MASK = 14'(LEAF_BYTES - 1);

    t_state r_state, n_state;

    logic [15:0]      r_size, n_size;
    logic [13:0]      r_quo, n_quo;
    logic [13:0]      r_rem, n_rem;
    logic [ORD_W-1:0] r_ord, n_ord;
    logic [ORD_W-1:0] r_i, n_i;
    logic [LW-1:0]    r_leaf, n_leaf;
    logic [LW-1:0]    r_clr, n_clr;
    t_result          r_res, n_res;
    logic [KW-1:0]    r_heads [TOP_ORDER+1];

    // Memory ports.
    logic             tag_we, tag_re, nxt_we, nxt_re, prv_we, prv_re;
    logic [LW-1:0]    tag_wa, tag_ra, nxt_wa, nxt_ra, prv_wa, prv_ra;
    logic [TAG_W-1:0] tag_wd, tag_rd;
    logic [KW-1:0]    nxt_wd, nxt_rd, prv_wd, prv_rd;

    // Free list head port.
    logic             h_we;
    logic [HIW-1:0]   h_wa, h_ra;
    logic [KW-1:0]    h_wd, h_rd;

    // Size rounding and list search of an allocate.
    logic [16:0]      need;
    logic             fit_ok, found;
    logic [ORD_W-1:0] fit_ord, found_ord;
    logic [KW-1:0]    found_head;

    // Working values.
    logic [ORD_W-1:0] im1, tag_ord;
    logic [LW-1:0]    bit_i, bit_o;
    logic [13:0]      start_b;

    bba_ram #(.WIDTH(TAG_W), .DEPTH(NLEAF)) u_tags (
        .i_clk(i_clk), .i_we(tag_we), .i_waddr(tag_wa), .i_wdata(tag_wd),
        .i_re(tag_re), .i_raddr(tag_ra), .o_rdata(tag_rd)
    );

    bba_ram #(.WIDTH(KW), .DEPTH(NLEAF)) u_next (
        .i_clk(i_clk), .i_we(nxt_we), .i_waddr(nxt_wa), .i_wdata(nxt_wd),
        .i_re(nxt_re), .i_raddr(nxt_ra), .o_rdata(nxt_rd)
    );

    bba_ram #(.WIDTH(KW), .DEPTH(NLEAF)) u_prev (
        .i_clk(i_clk), .i_we(prv_we), .i_waddr(prv_wa), .i_wdata(prv_wd),
        .i_re(prv_re), .i_raddr(prv_ra), .o_rdata(prv_rd)
    );

    assign h_rd    = r_heads[h_ra];
    assign im1     = r_i - ORD_W'(1);
    assign bit_i   = LW'(1) << im1;
    assign bit_o   = LW'(1) << r_ord;
    assign tag_ord = (tag_rd[ORD_W-1:0] > TOP_ORD) ? TOP_ORD : tag_rd[ORD_W-1:0];
    assign start_b = i_address - 14'(HEADER_BYTES);

    // Smallest fitting order and lowest non-empty list at or above it.
    always_comb begin
        need       = 17'(r_size) + 17'(HEADER_BYTES);
        fit_ok     = 1'b0;
        fit_ord    = '0;
        found      = 1'b0;
        found_ord  = '0;
        found_head = NIL;
        for (int k = TOP_ORDER; k >= 0; k--) begin
            if ((64'(LEAF_BYTES) << k) >= 64'(need)) begin
                fit_ok  = 1'b1;
                fit_ord = ORD_W'(k);
            end
        end
        for (int k = TOP_ORDER; k >= 0; k--) begin
            if (ORD_W'(k) >= fit_ord && r_heads[k] != NIL) begin
                found      = 1'b1;
                found_ord  = ORD_W'(k);
                found_head = r_heads[k];
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_ALLOC) begin
                        n_state = S_A_SIZE;
                    end else if (i_address < 14'(HEADER_BYTES)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_F_CHECK;
                    end
                end
            end
            S_A_SIZE: begin
                if (r_size != '0 && fit_ok && found) n_state = S_A_UNLINK;
                else n_state = S_DONE;
            end
            S_A_UNLINK: n_state = (r_i > r_ord) ? S_A_SPLIT : S_A_MARK;
            S_A_SPLIT:  n_state = S_A_SPLIT2;
            S_A_SPLIT2: n_state = (im1 > r_ord) ? S_A_SPLIT : S_A_MARK;
            S_A_MARK:   n_state = S_DONE;
            S_F_CHECK: begin
                if (r_rem == '0 && 28'(r_quo) < 28'(NLEAF)) n_state = S_F_TAG;
                else n_state = S_DONE;
            end
            S_F_TAG: begin
                if (!tag_rd[ORD_W]) n_state = S_DONE;
                else if (tag_ord < TOP_ORD) n_state = S_F_BUDDY;
                else n_state = S_F_PUSH;
            end
            S_F_BUDDY: n_state = S_F_BCHK;
            S_F_BCHK: begin
                if (tag_rd[ORD_W] || tag_rd[ORD_W-1:0] != r_ord) n_state = S_F_PUSH;
                else n_state = S_F_UNLINK;
            end
            S_F_UNLINK: begin
                n_state = (r_ord + ORD_W'(1) < TOP_ORD) ? S_F_BUDDY : S_F_PUSH;
            end
            S_F_PUSH:  n_state = S_F_PUSH2;
            S_F_PUSH2: n_state = S_DONE;
            // The result waits here while the output register is still held.
            S_DONE:    n_state = i_hold ? S_DONE : S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory control and next values of the working registers.
    always_comb begin
        tag_we = 1'b0; tag_wa = '0; tag_wd = '0; tag_re = 1'b0; tag_ra = '0;
        nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_re = 1'b0; nxt_ra = '0;
        prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_re = 1'b0; prv_ra = '0;
        h_we   = 1'b0; h_wa   = '0; h_wd   = '0; h_ra   = '0;
        n_size = r_size; n_quo = r_quo; n_rem = r_rem;
        n_ord  = r_ord;  n_i   = r_i;   n_leaf = r_leaf; n_clr = r_clr;
        n_res  = r_res;
        case (r_state)
            S_CLEAR: begin
                // One entry of each memory a cycle: top order, free, null links.
                tag_we = 1'b1; tag_wa = r_clr; tag_wd = {1'b0, TOP_ORD};
                nxt_we = 1'b1; nxt_wa = r_clr; nxt_wd = NIL;
                prv_we = 1'b1; prv_wa = r_clr; prv_wd = NIL;
                n_clr  = r_clr + LW'(1);
            end
            S_IDLE: begin
                // Leaf index and leaf offset of the block start.
                n_size = i_size_bytes;
                n_quo  = start_b >> LB_SH;
                n_rem  = start_b & LB_MASK;
                n_res  = '0;
                n_res.status = (i_op == OP_ALLOC) ? ST_GRANTED : ST_IGNORED;
            end
            S_A_SIZE: begin
                // Take the head of the chosen list and fetch its successor.
                n_ord  = fit_ord;
                n_i    = found_ord;
                n_leaf = found_head[LW-1:0];
                nxt_re = 1'b1;
                nxt_ra = found_head[LW-1:0];
                if (r_size == '0) n_res.status = ST_ZERO;
                else if (!fit_ok) n_res.status = ST_TOO_LARGE;
                else if (!found) n_res.status = ST_NO_MEMORY;
            end
            S_A_UNLINK: begin
                h_we = 1'b1; h_wa = HIW'(r_i); h_wd = nxt_rd;
                if (nxt_rd != NIL) begin
                    prv_we = 1'b1; prv_wa = nxt_rd[LW-1:0]; prv_wd = NIL;
                end
            end
            S_A_SPLIT: begin
                // Upper half becomes a free block one order down.
                h_ra   = HIW'(im1);
                tag_we = 1'b1; tag_wa = r_leaf | bit_i; tag_wd = {1'b0, im1};
                nxt_we = 1'b1; nxt_wa = r_leaf | bit_i; nxt_wd = h_rd;
                prv_we = 1'b1; prv_wa = r_leaf | bit_i; prv_wd = NIL;
            end
            S_A_SPLIT2: begin
                h_ra = HIW'(im1);
                if (h_rd != NIL) begin
                    prv_we = 1'b1; prv_wa = h_rd[LW-1:0]; prv_wd = KW'(r_leaf | bit_i);
                end
                h_we = 1'b1; h_wa = HIW'(im1); h_wd = KW'(r_leaf | bit_i);
                n_i  = im1;
            end
            S_A_MARK: begin
                tag_we = 1'b1; tag_wa = r_leaf; tag_wd = {1'b1, r_ord};
                n_res.data_address = 14'(r_leaf) * 14'(LEAF_BYTES) + 14'(HEADER_BYTES);
                n_res.block_order  = 4'(r_ord);
            end
            S_F_CHECK: begin
                n_leaf = LW'(r_quo);
                tag_re = 1'b1;
                tag_ra = LW'(r_quo);
            end
            S_F_TAG: begin
                if (tag_rd[ORD_W]) begin
                    n_ord  = tag_ord;
                    tag_we = 1'b1; tag_wa = r_leaf; tag_wd = {1'b0, tag_ord};
                end
            end
            S_F_BUDDY: begin
                tag_re = 1'b1; tag_ra = r_leaf ^ bit_o;
            end
            S_F_BCHK: begin
                nxt_re = 1'b1; nxt_ra = r_leaf ^ bit_o;
                prv_re = 1'b1; prv_ra = r_leaf ^ bit_o;
            end
            S_F_UNLINK: begin
                // Remove the buddy from its list and merge one order up.
                if (prv_rd != NIL) begin
                    nxt_we = 1'b1; nxt_wa = prv_rd[LW-1:0]; nxt_wd = nxt_rd;
                end else begin
                    h_we = 1'b1; h_wa = HIW'(r_ord); h_wd = nxt_rd;
                end
                if (nxt_rd != NIL) begin
                    prv_we = 1'b1; prv_wa = nxt_rd[LW-1:0]; prv_wd = prv_rd;
                end
                tag_we = 1'b1; tag_wa = r_leaf & ~bit_o;
                tag_wd = {1'b0, r_ord + ORD_W'(1)};
                n_leaf = r_leaf & ~bit_o;
                n_ord  = r_ord + ORD_W'(1);
            end
            S_F_PUSH: begin
                h_ra   = HIW'(r_ord);
                nxt_we = 1'b1; nxt_wa = r_leaf; nxt_wd = h_rd;
                prv_we = 1'b1; prv_wa = r_leaf; prv_wd = NIL;
            end
            S_F_PUSH2: begin
                h_ra = HIW'(r_ord);
                if (h_rd != NIL) begin
                    prv_we = 1'b1; prv_wa = h_rd[LW-1:0]; prv_wd = KW'(r_leaf);
                end
                h_we = 1'b1; h_wa = HIW'(r_ord); h_wd = KW'(r_leaf);
                n_res.status      = ST_FREED;
                n_res.block_order = 4'(r_ord);
            end
            default: begin
            end
        endcase
    end

    // Control state and free list heads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            for (int k = 0; k <= TOP_ORDER; k++) begin
                r_heads[k] <= (k == TOP_ORDER) ? KW'(0) : NIL;
            end
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (h_we) r_heads[h_wa] <= h_wd;
        end
    end

    // Working registers.
    always_ff @(posedge i_clk) begin
        r_size <= n_size;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_ord  <= n_ord;
        r_i    <= n_i;
        r_leaf <= n_leaf;
        r_res  <= n_res;
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE) && !i_hold;
    assign o_result = r_res;

endmodule

// ----- tb/sv/tb.sv -----
// Testbench of the buddy block allocator: directed table, random traffic, free-list predictor.
`timescale 1ns / 100ps
module tb;
    import bba_pkg::*;

    localparam int NLEAF    = 1024;
    localparam int TOP_ORD  = 10;
    localparam int LEAF_B   = 16;
    localparam int HDR_B    = 16;
    localparam int NO_LINK  = NLEAF;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = OP_ALLOC;
    logic [15:0] i_size_bytes = '0;
    logic [13:0] i_address = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [13:0] o_data_address;
    logic [3:0]  o_block_order;

    buddy_block_allocator i_dut (.*);

    // Clock generation.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor state: tags hold order plus a used flag.
    logic [4:0]  pool_order [NLEAF];
    logic        pool_used [NLEAF];
    int          link_next [NLEAF];
    int          link_prev [NLEAF];
    int          list_head [TOP_ORD + 1];
    t_result     pending_results [$];
    int          granted_addrs [$];
    int          fail_count = 0;
    bit          hold_off = 1'b0;
    bit          idle_free = 1'b0;

    // Directed rows: op, size, address, check flag, expected result.
    typedef struct {
        logic        op;
        logic [15:0] size;
        logic [13:0] addr;
        bit          fixed;
        t_result     res;
    } t_row;

    function automatic void push_free(int ord, int leaf);
        link_next[leaf] = list_head[ord];
        link_prev[leaf] = NO_LINK;
        if (list_head[ord] < NLEAF) link_prev[list_head[ord]] = leaf;
        list_head[ord] = leaf;
    endfunction

    function automatic void unlink_free(int ord, int leaf);
        int nx;
        int pv;
        nx = link_next[leaf];
        pv = link_prev[leaf];
        if (pv < NLEAF) link_next[pv] = nx;
        else list_head[ord] = nx;
        if (nx < NLEAF) link_prev[nx] = pv;
        link_next[leaf] = NO_LINK;
        link_prev[leaf] = NO_LINK;
    endfunction

    // Works out the result of one word and updates the pool copy.
    function automatic t_result predict_pool(logic op, logic [15:0] size, logic [13:0] addr);
        t_result r;
        int need;
        int ord;
        int o;
        int leaf;
        int buddy;
        int start;
        r = '0;
        if (op == OP_ALLOC) begin
            if (size == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            need = size + HDR_B;
            ord = 0;
            while ((LEAF_B << ord) < need) begin
                ord++;
                if (ord > TOP_ORD) begin
                    r.status = ST_TOO_LARGE;
                    return r;
                end
            end
            for (o = ord; o <= TOP_ORD; o++)
                if (list_head[o] < NLEAF) break;
            if (o > TOP_ORD) begin
                r.status = ST_NO_MEMORY;
                return r;
            end
            leaf = list_head[o];
            unlink_free(o, leaf);
            for (int i = o; i > ord; i--) begin
                pool_order[leaf + (1 << (i - 1))] = 5'(i - 1);
                pool_used[leaf + (1 << (i - 1))] = 1'b0;
                push_free(i - 1, leaf + (1 << (i - 1)));
            end
            pool_order[leaf] = 5'(ord);
            pool_used[leaf] = 1'b1;
            r.status = ST_GRANTED;
            r.data_address = 14'(leaf * LEAF_B + HDR_B);
            r.block_order = 4'(ord);
            return r;
        end
        r.status = ST_IGNORED;
        if (addr < HDR_B) return r;
        start = addr - HDR_B;
        if (start % LEAF_B != 0 || start / LEAF_B >= NLEAF) return r;
        leaf = start / LEAF_B;
        if (!pool_used[leaf]) return r;
        ord = pool_order[leaf];
        if (ord > TOP_ORD) ord = TOP_ORD;
        pool_used[leaf] = 1'b0;
        pool_order[leaf] = 5'(ord);
        while (ord < TOP_ORD) begin
            buddy = leaf ^ (1 << ord);
            if (pool_used[buddy] || pool_order[buddy] != ord) break;
            unlink_free(ord, buddy);
            if (buddy < leaf) leaf = buddy;
            ord++;
            pool_order[leaf] = 5'(ord);
            pool_used[leaf] = 1'b0;
        end
        push_free(ord, leaf);
        r.status = ST_FREED;
        r.block_order = 4'(ord);
        return r;
    endfunction

    // Offers one word, waits for acceptance, and queues its expected result.
    // Valid stays high into the next call; the caller drops it before pausing.
    task automatic send_word(logic op, logic [15:0] size, logic [13:0] addr,
                             bit fixed, t_result res);
        t_result p;
        if (!idle_free && $urandom_range(99) < 15) begin
            i_valid <= 1'b0;
            do @(negedge i_clk); while (!idle_free && $urandom_range(99) < 15);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_size_bytes <= size;
        i_address <= addr;
        do @(posedge i_clk); while (o_stall);
        p = predict_pool(op, size, addr);
        if (p.status == ST_GRANTED) granted_addrs.push_back(p.data_address);
        if (fixed && p !== res) begin
            $display("%0t directed row disagrees with predictor: expected %h got %h",
                     $time, res, p);
            fail_count++;
        end
        pending_results.push_back(fixed ? res : p);
        @(negedge i_clk);
    endtask

    // Result checking at the rising edge.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected word: status %0d", $time, o_status);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_data_address !== want.data_address ||
                    o_block_order !== want.block_order) begin
                    $display("%0t mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
                             $time, want.status, want.data_address, want.block_order,
                             o_status, o_data_address, o_block_order);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall: random, never during the idle-free stretch, or held high for a long stretch.
    always @(negedge i_clk) begin
        if (hold_off) i_stall <= 1'b1;
        else if (idle_free) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 15);
    end

    initial begin
        #30_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        t_row rows [$];
        t_result none;
        int k;
        int pick;
        none = '0;
        for (int i = 0; i < NLEAF; i++) begin
            pool_order[i] = 5'(TOP_ORD);
            pool_used[i] = 1'b0;
            link_next[i] = NO_LINK;
            link_prev[i] = NO_LINK;
        end
        for (int i = 0; i <= TOP_ORD; i++) list_head[i] = NO_LINK;
        list_head[TOP_ORD] = 0;

        // Directed rows.
        rows.push_back('{OP_FREE, 16'd0, 14'd16, 1, '{ST_IGNORED, 14'd0, 4'd0}});
        rows.push_back('{OP_ALLOC, 16'd0, 14'h3FFF, 1, '{ST_ZERO, 14'd0, 4'd0}});
        rows.push_back('{OP_ALLOC, 16'hFFFF, 14'd0, 1, '{ST_TOO_LARGE, 14'd0, 4'd0}});
        rows.push_back('{OP_ALLOC, 16'd16369, 14'd0, 1, '{ST_TOO_LARGE, 14'd0, 4'd0}});
        rows.push_back('{OP_ALLOC, 16'd16368, 14'd0, 1, '{ST_GRANTED, 14'd16, 4'd10}});
        rows.push_back('{OP_ALLOC, 16'd1, 14'd0, 1, '{ST_NO_MEMORY, 14'd0, 4'd0}});
        rows.push_back('{OP_FREE, 16'hFFFF, 14'd16, 1, '{ST_FREED, 14'd0, 4'd10}});
        rows.push_back('{OP_FREE, 16'd0, 14'd16, 1, '{ST_IGNORED, 14'd0, 4'd0}});
        rows.push_back('{OP_ALLOC, 16'd1, 14'd0, 1, '{ST_GRANTED, 14'd16, 4'd1}});
        rows.push_back('{OP_ALLOC, 16'd100, 14'd0, 0, none});
        rows.push_back('{OP_ALLOC, 16'd17, 14'd0, 0, none});
        rows.push_back('{OP_FREE, 16'd0, 14'd17, 1, '{ST_IGNORED, 14'd0, 4'd0}});
        rows.push_back('{OP_FREE, 16'd0, 14'd15, 1, '{ST_IGNORED, 14'd0, 4'd0}});
        rows.push_back('{OP_FREE, 16'd0, 14'h3FFF, 1, '{ST_IGNORED, 14'd0, 4'd0}});
        rows.push_back('{OP_FREE, 16'd0, 14'd48, 0, none});
        rows.push_back('{OP_FREE, 16'd0, 14'd16, 0, none});
        rows.push_back('{OP_ALLOC, 16'd8000, 14'd0, 0, none});

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (rows[r]) send_word(rows[r].op, rows[r].size, rows[r].addr,
                                    rows[r].fixed, rows[r].res);

        // Random traffic; a quiet stretch with no idling in the middle.
        for (k = 0; k < 1900; k++) begin
            idle_free = (k >= 600 && k < 800);
            if (k == 300) begin
                // Sender pauses until every result has come.
                i_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge i_clk);
            end
            if (k == 1000) fork
                begin
                    hold_off = 1'b1;
                    repeat (400) @(negedge i_clk);
                    hold_off = 1'b0;
                end
            join_none
            pick = $urandom_range(99);
            if (pick < 50) begin
                if ($urandom_range(9) < 8)
                    send_word(OP_ALLOC, 16'($urandom_range(1, 1 << $urandom_range(4, 12))),
                              14'($urandom), 0, none);
                else
                    send_word(OP_ALLOC, 16'($urandom), 14'($urandom), 0, none);
            end else if (pick < 90 && granted_addrs.size() > 0) begin
                int j;
                j = $urandom_range(granted_addrs.size() - 1);
                send_word(OP_FREE, 16'($urandom), 14'(granted_addrs[j]), 0, none);
                granted_addrs.delete(j);
            end else begin
                send_word(OP_FREE, 16'($urandom), 14'($urandom), 0, none);
            end
        end
        i_valid <= 1'b0;
        idle_free = 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule

// ----- buddy_block_allocator.f -----
+incdir+hw/rtl
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/bba_ctrl.sv
hw/rtl/buddy_block_allocator.sv
tb/sv/tb.sv
